### rtl/cpc_pkg.sv
// ----------------------------------------------------------------------------
// cpc_pkg: shared types and constants of the cable pinout checker
// Result kinds, frame character codes and the parser-to-datapath struct.
// ----------------------------------------------------------------------------
package cpc_pkg;

  // Width of a pin index on the ports and in the parser registers.
  localparam int unsigned PinW = 6;

  typedef enum logic [1:0] {
    KIND_LOADED  = 2'd0,
    KIND_OPEN    = 2'd1,
    KIND_SHORT   = 2'd2,
    KIND_VERDICT = 2'd3
  } kind_e;

  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_AMP    = 8'h26;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_DASH   = 8'h2D;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_ZERO   = 8'd48;

  // What the parser asks of the map for one character.
  typedef struct packed {
    logic            mark;    // set the cell at row/col
    logic [PinW-1:0] row;     // current row, also the map read address
    logic [PinW-1:0] col;     // column of the cell to mark
    logic            clear;   // start of a frame: empty the map
    logic            loaded;  // end of a frame: report the map as loaded
  } parse_t;

endpackage

### rtl/cable_pinout_checker.sv
// ----------------------------------------------------------------------------
// cable_pinout_checker: expected pinout loader and measured cell checker
// A transaction is accepted in IDLE and its map row is read at acceptance;
// EXEC works on that row, and its first result is registered onto the result
// ports at the end of EXEC. A new transaction is only taken in IDLE, after the
// map read-modify-write; a fault that also ends a scan then passes VERDICT.
// Reset clears the parser, the mismatch flag and the map valid bits at once;
// the result receiver cannot stall, so results are never held back.
// ----------------------------------------------------------------------------
module cable_pinout_checker #(
  parameter int unsigned PINS = 40
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  output logic                       busy_o,
  input  logic                       action_i,
  input  logic [7:0]                 char_in_i,
  input  logic [cpc_pkg::PinW-1:0]   cell_row_i,
  input  logic [cpc_pkg::PinW-1:0]   cell_col_i,
  input  logic                       connected_i,
  input  logic                       end_of_scan_i,
  output logic                       result_strobe_o,
  output cpc_pkg::kind_e             kind_o,
  output logic [cpc_pkg::PinW-1:0]   fault_row_o,
  output logic [cpc_pkg::PinW-1:0]   fault_col_o,
  output logic                       pass_o,
  output logic                       last_o
);
  import cpc_pkg::*;

  localparam int unsigned AW = (PINS > 1) ? $clog2(PINS) : 1;

  // IDLE takes a transaction, EXEC works on the map row read for it, and
  // VERDICT sends the scan verdict that follows a fault on the last cell.
  typedef enum logic [1:0] {
    ST_IDLE    = 2'd0,
    ST_EXEC    = 2'd1,
    ST_VERDICT = 2'd2
  } state_e;

  state_e          state_q;
  logic            accept;

  // Captured transaction.
  logic            action_q;
  logic [7:0]      char_q;
  logic [PinW-1:0] row_q;
  logic [PinW-1:0] col_q;
  logic            conn_q;
  logic            eos_q;

  logic            mismatch_q;
  logic            verdict_pass_q;

  // Registered result ports.
  logic            strobe_q;
  kind_e           kind_q;
  logic [PinW-1:0] fault_row_q;
  logic [PinW-1:0] fault_col_q;
  logic            pass_q;
  logic            last_q;

  parse_t          parse;
  logic [AW-1:0]   rd_addr;
  logic [PINS-1:0] rd_data;
  logic            wr_en;
  logic [PINS-1:0] wr_data;

  logic            cell_in_range;
  logic            expected;
  logic            mismatch;

  assign accept = start_i && (state_q == ST_IDLE);
  assign busy_o = (state_q != ST_IDLE);

  // A text character works on the parser's current row; a measured cell
  // reads the row of its driven pin. Parser rows are always in range.
  assign rd_addr = action_i ? cell_row_i[AW-1:0] : parse.row[AW-1:0];

  cpc_parser #(
    .PINS (PINS)
  ) u_parser (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  ((state_q == ST_EXEC) && !action_q),
    .char_i  (char_q),
    .parse_o (parse)
  );

  // The row is read at acceptance and written back at the end of EXEC. A
  // new transaction is only taken in IDLE, so a read never meets a pending
  // write to the same row.
  assign wr_en   = parse.mark;
  assign wr_data = rd_data | (PINS'(1) << parse.col[AW-1:0]);

  cpc_map_mem #(
    .PINS (PINS),
    .AW   (AW)
  ) u_map (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .clr_i     (parse.clear),
    .rd_en_i   (accept),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data),
    .wr_en_i   (wr_en),
    .wr_addr_i (parse.row[AW-1:0]),
    .wr_data_i (wr_data)
  );

  // Cells outside the pin range are never reported as faults.
  assign cell_in_range = (row_q < PinW'(PINS - 1)) || (row_q == PinW'(PINS - 1));
  assign expected      = rd_data[col_q[AW-1:0]];
  assign mismatch      = action_q && cell_in_range
                         && ((col_q < PinW'(PINS - 1)) || (col_q == PinW'(PINS - 1)))
                         && (expected != conn_q);

  always_ff @(posedge clk_i) begin
    if (accept) begin
      action_q <= action_i;
      char_q   <= char_in_i;
      row_q    <= cell_row_i;
      col_q    <= cell_col_i;
      conn_q   <= connected_i;
      eos_q    <= end_of_scan_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      mismatch_q     <= 1'b0;
      verdict_pass_q <= 1'b0;
      strobe_q       <= 1'b0;
      kind_q         <= KIND_LOADED;
      fault_row_q    <= '0;
      fault_col_q    <= '0;
      pass_q         <= 1'b0;
      last_q         <= 1'b0;
    end else begin
      strobe_q <= 1'b0;
      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            state_q <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          state_q <= ST_IDLE;
          if (!action_q) begin
            if (parse.loaded) begin
              strobe_q    <= 1'b1;
              kind_q      <= KIND_LOADED;
              fault_row_q <= '0;
              fault_col_q <= '0;
              pass_q      <= 1'b0;
              last_q      <= 1'b1;
            end
          end else if (mismatch) begin
            strobe_q    <= 1'b1;
            kind_q      <= conn_q ? KIND_SHORT : KIND_OPEN;
            fault_row_q <= row_q;
            fault_col_q <= col_q;
            pass_q      <= 1'b0;
            last_q      <= !eos_q;
            if (eos_q) begin
              // The verdict follows in the next cycle and covers this fault.
              verdict_pass_q <= 1'b0;
              mismatch_q     <= 1'b0;
              state_q        <= ST_VERDICT;
            end else begin
              mismatch_q <= 1'b1;
            end
          end else if (eos_q) begin
            strobe_q    <= 1'b1;
            kind_q      <= KIND_VERDICT;
            fault_row_q <= '0;
            fault_col_q <= '0;
            pass_q      <= !mismatch_q;
            last_q      <= 1'b1;
            mismatch_q  <= 1'b0;
          end
        end
        ST_VERDICT: begin
          strobe_q    <= 1'b1;
          kind_q      <= KIND_VERDICT;
          fault_row_q <= '0;
          fault_col_q <= '0;
          pass_q      <= verdict_pass_q;
          last_q      <= 1'b1;
          state_q     <= ST_IDLE;
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign result_strobe_o = strobe_q;
  assign kind_o          = kind_q;
  assign fault_row_o     = fault_row_q;
  assign fault_col_o     = fault_col_q;
  assign pass_o          = pass_q;
  assign last_o          = last_q;

endmodule

### rtl/cpc_map_mem.sv
// ----------------------------------------------------------------------------
// cpc_map_mem: expected connection matrix storage
// One row per driven pin, one synchronous read and one write port. A row
// valid bit per entry makes a cleared row read as all zeros.
// ----------------------------------------------------------------------------
module cpc_map_mem #(
  parameter int unsigned PINS = 40,
  parameter int unsigned AW   = (PINS > 1) ? $clog2(PINS) : 1
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            clr_i,
  input  logic            rd_en_i,
  input  logic [AW-1:0]   rd_addr_i,
  output logic [PINS-1:0] rd_data_o,
  input  logic            wr_en_i,
  input  logic [AW-1:0]   wr_addr_i,
  input  logic [PINS-1:0] wr_data_i
);

  logic [PINS-1:0] mem_q [PINS];
  logic [PINS-1:0] rd_data_q;
  logic            rd_valid_q;
  logic [PINS-1:0] valid_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (clr_i) begin
        valid_q <= '0;
      end
      if (wr_en_i) begin
        valid_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_valid_q <= valid_q[rd_addr_i];
      end
    end
  end

  assign rd_data_o = rd_valid_q ? rd_data_q : '0;

endmodule

### rtl/cpc_parser.sv
// ----------------------------------------------------------------------------
// cpc_parser: frame parser for the expected pinout text
// Tracks the frame phase and the current row and column, and tells the
// datapath which cell to mark, when to clear the map and when a frame ends.
// ----------------------------------------------------------------------------
module cpc_parser #(
  parameter int unsigned PINS = 40
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            step_i,
  input  logic [7:0]      char_i,
  output cpc_pkg::parse_t parse_o
);
  import cpc_pkg::*;

  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_ROW0  = 3'd1,
    PH_BODY  = 3'd2,
    PH_COL   = 3'd3,
    PH_COMMA = 3'd4,
    PH_HASH  = 3'd5
  } phase_e;

  phase_e          phase_q, phase_d;
  logic [PinW-1:0] row_q, row_d;
  logic [PinW-1:0] col_q, col_d;
  logic [7:0]      digit;
  logic            digit_ok;
  parse_t          p;

  // Digits are the character code minus '0', taken modulo 256.
  assign digit    = char_i - CH_ZERO;
  assign digit_ok = digit < 8'(PINS);

  always_comb begin
    phase_d = phase_q;
    row_d   = row_q;
    col_d   = col_q;
    p       = '0;
    p.row   = row_q;
    p.col   = col_q;
    case (phase_q)
      PH_IDLE: begin
        if (char_i == CH_DOLLAR) begin
          p.clear = 1'b1;
          phase_d = PH_ROW0;
        end
      end
      PH_ROW0: begin
        if (digit_ok) begin
          row_d = digit[PinW-1:0];
        end
        phase_d = PH_BODY;
      end
      PH_BODY: begin
        if (char_i == CH_AMP) begin
          p.loaded = 1'b1;
          phase_d  = PH_IDLE;
        end else if (char_i == CH_DASH) begin
          phase_d = PH_COL;
        end else if (char_i == CH_COMMA) begin
          phase_d = PH_COMMA;
        end else begin
          p.mark = 1'b1;
        end
      end
      PH_COMMA: begin
        if (char_i == CH_HASH) begin
          phase_d = PH_HASH;
        end else begin
          if (digit_ok) begin
            col_d  = digit[PinW-1:0];
            p.col  = digit[PinW-1:0];
            p.mark = 1'b1;
          end
          phase_d = PH_BODY;
        end
      end
      PH_COL: begin
        if (digit_ok) begin
          col_d  = digit[PinW-1:0];
          p.col  = digit[PinW-1:0];
          p.mark = 1'b1;
        end
        phase_d = PH_BODY;
      end
      PH_HASH: begin
        if (char_i == CH_NL || char_i == CH_AMP) begin
          p.loaded = 1'b1;
          phase_d  = PH_IDLE;
        end else begin
          if (digit_ok) begin
            row_d = digit[PinW-1:0];
          end
          phase_d = PH_BODY;
        end
      end
      default: begin
        phase_d = PH_IDLE;
      end
    endcase
    if (!step_i) begin
      p.mark   = 1'b0;
      p.clear  = 1'b0;
      p.loaded = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      row_q   <= '0;
      col_q   <= '0;
    end else if (step_i) begin
      phase_q <= phase_d;
      row_q   <= row_d;
      col_q   <= col_d;
    end
  end

  assign parse_o = p;

endmodule
